FILE: hw/rtl/awslm_pkg.sv
// package: shared types, coefficients and constants of the sound level meter
`default_nettype none
package awslm_pkg;

  localparam int unsigned FrameW  = 32;
  localparam int unsigned OffsetW = 14;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned AccW    = 64;
  localparam int unsigned StateW  = 32;

  // stage 1 and 2 coefficients, Q2.22
  localparam logic signed [23:0] B10 = 24'sd2002052;
  localparam logic signed [23:0] B11 = 24'sd1941726;
  localparam logic signed [23:0] B12 = 24'sd470802;
  localparam logic signed [23:0] A10 = 24'sd280261;
  localparam logic signed [23:0] A11 = 24'sd4678;
  localparam logic signed [23:0] B20 = 24'sd4194304;
  localparam logic signed [23:0] B21 = -24'sd8342719;
  localparam logic signed [23:0] B22 = 24'sd4148541;
  localparam logic signed [23:0] A20 = -24'sd8378346;
  localparam logic signed [23:0] A21 = 24'sd4184048;

  localparam logic [17:0] K10 = 18'd197283;
  localparam logic [18:0] K20 = 19'd394566;
  localparam logic [6:0]  MeanFloor = 7'd110;
  localparam logic signed [18:0] DbLow  = 19'sd5120;
  localparam logic signed [18:0] DbHigh = 19'sd33280;
  localparam logic signed [18:0] DbBase = 19'sd30720;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MAC_FB0, OP_MAC_FB1, OP_W, OP_MAC_FF0, OP_MAC_FF1,
    OP_MAC_FF2, OP_Y, OP_ACC, OP_DIV, OP_LOG_INIT, OP_LOG_STEP, OP_LOG_DONE,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       stage;
    logic       sel_peak;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic log_done;
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/awslm_if.sv
// interfaces: input and result channels with valid/ready handshake
`default_nettype none
interface awslm_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_frame;
  logic        window_end;
  modport source (output valid, output raw_frame, output window_end, input ready);
  modport sink (input valid, input raw_frame, input window_end, output ready);
endinterface

interface awslm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] leq_db_q8;
  logic [15:0] peak_db_q8;
  logic [16:0] window_samples;
  modport source (output valid, output leq_db_q8, output peak_db_q8,
                  output window_samples, input ready);
  modport sink (input valid, input leq_db_q8, input peak_db_q8,
                input window_samples, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/awslm_datapath.sv
// datapath: shared multiplier biquad, accumulators, serial divider and log unit
`default_nettype none
module awslm_datapath #(
  parameter int unsigned WindowMax = 65536
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  awslm_pkg::cmd_t     cmd_i,
  output awslm_pkg::sts_t     sts_o,
  input  wire  [31:0]         raw_frame_i,
  input  wire  signed [13:0]  offset_i,
  output logic [15:0]         leq_o,
  output logic [15:0]         peak_o,
  output logic [16:0]         count_o
);
  localparam int unsigned CntW = $clog2(WindowMax + 1);

  logic signed [31:0] z_q [4];
  logic signed [31:0] s_q, w_q;
  logic signed [63:0] mac_q;
  logic [63:0]        acc_q;
  logic [31:0]        peak_q;
  logic [CntW-1:0]    cnt_q;
  logic [63:0]        rem_q, quo_q;
  logic [6:0]         dcnt_q;
  logic [32:0]        m_q;
  logic [5:0]         e_q;
  logic [15:0]        frac_q;
  logic [4:0]         lcnt_q;
  logic [15:0]        leq_q, peak_db_q;

  logic signed [23:0] coef;
  logic signed [31:0] opnd;
  logic signed [55:0] prod;
  logic signed [63:0] rnd;
  logic signed [31:0] rnd_sat;
  logic signed [34:0] wsum;
  logic signed [31:0] wsat;
  logic [31:0]        mag;
  logic [63:0]        sq;
  logic [64:0]        accsum;
  logic [64:0]        dtrial;
  logic [63:0]        cnt_ext;
  logic [63:0]        logx;
  logic [5:0]         lz_e;
  logic [65:0]        msq;
  logic [32:0]        mnext;
  logic signed [22:0] lval;
  logic signed [42:0] dbprod;
  logic signed [18:0] db, lvl;
  logic [15:0]        lvl_c;
  logic [2:0]         zb;

  assign zb = {cmd_i.stage, 1'b0};

  always_comb begin
    coef = '0;
    opnd = '0;
    case (cmd_i.op)
      awslm_pkg::OP_MAC_FB0: begin
        coef = cmd_i.stage ? awslm_pkg::A20 : awslm_pkg::A10;
        opnd = z_q[zb[1:0]];
      end
      awslm_pkg::OP_MAC_FB1: begin
        coef = cmd_i.stage ? awslm_pkg::A21 : awslm_pkg::A11;
        opnd = z_q[zb[1:0] + 2'd1];
      end
      awslm_pkg::OP_MAC_FF0: begin
        coef = cmd_i.stage ? awslm_pkg::B20 : awslm_pkg::B10;
        opnd = w_q;
      end
      awslm_pkg::OP_MAC_FF1: begin
        coef = cmd_i.stage ? awslm_pkg::B21 : awslm_pkg::B11;
        opnd = z_q[zb[1:0]];
      end
      awslm_pkg::OP_MAC_FF2: begin
        coef = cmd_i.stage ? awslm_pkg::B22 : awslm_pkg::B12;
        opnd = z_q[zb[1:0] + 2'd1];
      end
      default: begin
        coef = '0;
        opnd = '0;
      end
    endcase
  end

  assign prod = coef * opnd;
  assign rnd  = (mac_q + 64'sd2097152) >>> 22;
  assign rnd_sat = (rnd > 64'sd2147483647) ? 32'sh7fffffff :
                   (rnd < -64'sd2147483648) ? 32'sh80000000 : rnd[31:0];
  assign wsum = 35'(s_q) - 35'(rnd);
  assign wsat = (wsum > 35'sd2147483647) ? 32'sh7fffffff :
                (wsum < -35'sd2147483648) ? 32'sh80000000 : wsum[31:0];
  assign mag    = s_q[31] ? 32'(-s_q) : s_q;
  assign sq     = (64'(mag) * 64'(mag)) >> 16;
  assign accsum = {1'b0, acc_q} + {1'b0, sq};
  assign cnt_ext = (cnt_q == '0) ? 64'd1 : 64'(cnt_q);
  assign dtrial = {rem_q, quo_q[63]} - {1'b0, cnt_ext};

  assign logx = cmd_i.sel_peak ? ((peak_q == '0) ? 64'd1 : 64'(peak_q))
              : ((quo_q < 64'(awslm_pkg::MeanFloor)) ? 64'(awslm_pkg::MeanFloor) : quo_q);

  always_comb begin
    lz_e = '0;
    for (int i = 0; i < 64; i++) begin
      if (logx[i]) lz_e = 6'(i);
    end
  end

  assign msq   = 66'(m_q) * 66'(m_q);
  assign mnext = msq[63:30] >= 34'h80000000 ? 33'(msq[63:31]) : 33'(msq[62:30]);

  assign lval  = cmd_i.sel_peak ? 23'sd0 : 23'sd0;
  always_comb begin
    logic signed [23:0] l2;
    l2 = $signed({2'b00, e_q, frac_q}) -
         (cmd_i.sel_peak ? 24'sd1835008 : 24'sd2621440);
    dbprod = cmd_i.sel_peak ? 43'(l2) * $signed({24'd0, awslm_pkg::K20})
                            : 43'(l2) * $signed({25'd0, awslm_pkg::K10});
  end
  assign db  = 19'((dbprod + 43'sd8388608) >>> 24) + 19'(lval);
  assign lvl = awslm_pkg::DbBase + db + 19'(offset_i);
  assign lvl_c = (lvl < awslm_pkg::DbLow) ? 16'(awslm_pkg::DbLow) :
                 (lvl > awslm_pkg::DbHigh) ? 16'(awslm_pkg::DbHigh) : lvl[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) z_q[i] <= '0;
      s_q       <= '0;
      w_q       <= '0;
      mac_q     <= '0;
      acc_q     <= '0;
      peak_q    <= '0;
      cnt_q     <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      dcnt_q    <= '0;
      m_q       <= '0;
      e_q       <= '0;
      frac_q    <= '0;
      lcnt_q    <= '0;
      leq_q     <= '0;
      peak_db_q <= '0;
    end else begin
      case (cmd_i.op)
        awslm_pkg::OP_LOAD: begin
          s_q   <= $signed({raw_frame_i[31:8], 5'd0}) ;
          mac_q <= '0;
        end
        awslm_pkg::OP_MAC_FB0, awslm_pkg::OP_MAC_FB1, awslm_pkg::OP_MAC_FF0,
        awslm_pkg::OP_MAC_FF1, awslm_pkg::OP_MAC_FF2: begin
          mac_q <= mac_q + 64'(prod);
        end
        awslm_pkg::OP_W: begin
          w_q   <= wsat;
          mac_q <= '0;
        end
        awslm_pkg::OP_Y: begin
          s_q <= rnd_sat;
          z_q[zb[1:0] + 2'd1] <= z_q[zb[1:0]];
          z_q[zb[1:0]] <= w_q;
          mac_q <= '0;
        end
        awslm_pkg::OP_ACC: begin
          acc_q <= accsum[64] ? '1 : accsum[63:0];
          if (mag > peak_q) peak_q <= mag;
          if (cnt_q < CntW'(WindowMax)) cnt_q <= cnt_q + 1'b1;
          quo_q  <= accsum[64] ? '1 : accsum[63:0];
          rem_q  <= '0;
          dcnt_q <= 7'd64;
        end
        awslm_pkg::OP_DIV: begin
          if (dcnt_q != '0) begin
            dcnt_q <= dcnt_q - 1'b1;
            if (!dtrial[64]) begin
              rem_q <= dtrial[63:0];
              quo_q <= {quo_q[62:0], 1'b1};
            end else begin
              rem_q <= {rem_q[62:0], quo_q[63]};
              quo_q <= {quo_q[62:0], 1'b0};
            end
          end
        end
        awslm_pkg::OP_LOG_INIT: begin
          e_q    <= lz_e;
          m_q    <= 33'((lz_e >= 6'd30) ? (logx >> (lz_e - 6'd30))
                                        : (logx << (6'd30 - lz_e)));
          frac_q <= '0;
          lcnt_q <= 5'd16;
        end
        awslm_pkg::OP_LOG_STEP: begin
          if (lcnt_q != '0) begin
            lcnt_q <= lcnt_q - 1'b1;
            m_q    <= mnext;
            frac_q <= {frac_q[14:0], (msq[63:30] >= 34'h80000000)};
          end
        end
        awslm_pkg::OP_LOG_DONE: begin
          if (cmd_i.sel_peak) peak_db_q <= lvl_c;
          else leq_q <= lvl_c;
        end
        awslm_pkg::OP_CLEAR: begin
          acc_q  <= '0;
          peak_q <= '0;
          cnt_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  assign sts_o.div_done = (dcnt_q == '0);
  assign sts_o.log_done = (lcnt_q == '0);
  assign leq_o   = leq_q;
  assign peak_o  = peak_db_q;
  assign count_o = 17'(cnt_q);

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(WindowMax)) else $error("sample count above limit");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == awslm_pkg::OP_CLEAR |=> acc_q == '0 && peak_q == '0)
    else $error("window state not cleared");
  a_log_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == awslm_pkg::OP_LOG_INIT |=> lcnt_q == 5'd16)
    else $error("log iteration count wrong");
endmodule
`default_nettype wire

FILE: hw/rtl/awslm_ctrl.sv
// controller: sequences filter and accumulate per beat, divide and log at window end
`default_nettype none
module awslm_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  input  wire              in_end_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output awslm_pkg::cmd_t  cmd_o,
  input  awslm_pkg::sts_t  sts_i
);
  localparam logic [3:0] S_IDLE = 4'd0, S_FB0 = 4'd1, S_FB1 = 4'd2, S_W = 4'd3,
    S_FF0 = 4'd4, S_FF1 = 4'd5, S_FF2 = 4'd6, S_Y = 4'd7, S_ACC = 4'd8,
    S_DIV = 4'd9, S_LINIT = 4'd10, S_LSTEP = 4'd11, S_LDONE = 4'd12,
    S_OUT = 4'd13;

  logic [3:0] state_q, state_d;
  logic       stage_q, stage_d, end_q, end_d, pk_q, pk_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    end_d   = end_q;
    pk_d    = pk_q;
    cmd_o.op       = awslm_pkg::OP_NONE;
    cmd_o.stage    = stage_q;
    cmd_o.sel_peak = pk_q;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.op = awslm_pkg::OP_LOAD;
        end_d = in_end_i;
        stage_d = 1'b0;
        state_d = S_FB0;
      end
      S_FB0: begin cmd_o.op = awslm_pkg::OP_MAC_FB0; state_d = S_FB1; end
      S_FB1: begin cmd_o.op = awslm_pkg::OP_MAC_FB1; state_d = S_W; end
      S_W:   begin cmd_o.op = awslm_pkg::OP_W; state_d = S_FF0; end
      S_FF0: begin cmd_o.op = awslm_pkg::OP_MAC_FF0; state_d = S_FF1; end
      S_FF1: begin cmd_o.op = awslm_pkg::OP_MAC_FF1; state_d = S_FF2; end
      S_FF2: begin cmd_o.op = awslm_pkg::OP_MAC_FF2; state_d = S_Y; end
      S_Y: begin
        cmd_o.op = awslm_pkg::OP_Y;
        stage_d = 1'b1;
        state_d = stage_q ? S_ACC : S_FB0;
      end
      S_ACC: begin
        cmd_o.op = awslm_pkg::OP_ACC;
        pk_d = 1'b0;
        state_d = end_q ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd_o.op = awslm_pkg::OP_DIV;
        if (sts_i.div_done) state_d = S_LINIT;
      end
      S_LINIT: begin cmd_o.op = awslm_pkg::OP_LOG_INIT; state_d = S_LSTEP; end
      S_LSTEP: begin
        cmd_o.op = awslm_pkg::OP_LOG_STEP;
        if (sts_i.log_done) state_d = S_LDONE;
      end
      S_LDONE: begin
        cmd_o.op = awslm_pkg::OP_LOG_DONE;
        pk_d = 1'b1;
        state_d = pk_q ? S_OUT : S_LINIT;
      end
      S_OUT: if (out_ready_i) begin
        cmd_o.op = awslm_pkg::OP_CLEAR;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      stage_q <= 1'b0;
      end_q   <= 1'b0;
      pk_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      end_q   <= end_d;
      pk_q    <= pk_d;
    end
  end

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready and valid together");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACC && end_q |=> state_q == S_DIV) else $error("no divide");
endmodule
`default_nettype wire

FILE: hw/rtl/a_weighted_sound_level_meter.sv
// top level: A-weighted equivalent and peak sound level meter
// One beat runs load, two biquad stages of 7 shared-multiplier steps and accumulate;
// a window-end beat adds a serial divide and two log2 passes before the result is
// offered. One beat in flight at a time.
`default_nettype none
module a_weighted_sound_level_meter #(
  parameter int unsigned WINDOW_MAX = 65536
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  awslm_in_if.sink     in_if,
  awslm_out_if.source  out_if,
  input  wire          cfg_we_i,
  input  wire  [13:0]  cfg_wdata_i
);
  awslm_pkg::cmd_t    cmd;
  awslm_pkg::sts_t    sts;
  logic signed [13:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) offset_q <= '0;
    else if (cfg_we_i) offset_q <= cfg_wdata_i;
  end

  awslm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid), .in_end_i (in_if.window_end),
    .in_ready_o (in_if.ready), .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready), .cmd_o (cmd), .sts_i (sts)
  );

  awslm_datapath #(.WindowMax(WINDOW_MAX)) u_dp (
    .clk_i, .rst_ni, .cmd_i (cmd), .sts_o (sts),
    .raw_frame_i (in_if.raw_frame), .offset_i (offset_q),
    .leq_o (out_if.leq_db_q8), .peak_o (out_if.peak_db_q8),
    .count_o (out_if.window_samples)
  );
endmodule
`default_nettype wire
